>>> hw/rtl/z80wl_pkg.sv
// Shared types, codes and constants of the Z80 16-bit load group unit.
// Used by the byte memory, the register file, the sequencer and the top level.
`timescale 1ns / 1ps

package z80wl_pkg;

    // Memory geometry.
    localparam int ADDR_BITS = 16;
    localparam int MEM_DEPTH = 1 << ADDR_BITS;
    localparam int REG_COUNT = 7;
    localparam int REG_IDX_BITS = 3;

    // Operation modes.
    localparam logic [3:0] M_LD_IMM   = 4'd0;
    localparam logic [3:0] M_LD_MEM   = 4'd1;
    localparam logic [3:0] M_ST_MEM   = 4'd2;
    localparam logic [3:0] M_LD_SP    = 4'd3;
    localparam logic [3:0] M_PUSH     = 4'd4;
    localparam logic [3:0] M_POP      = 4'd5;
    localparam logic [3:0] M_POKE     = 4'd6;
    localparam logic [3:0] M_PEEK_MEM = 4'd7;
    localparam logic [3:0] M_PEEK_REG = 4'd8;

    // Register pair indexes.
    localparam logic [2:0] R_BC = 3'd0;
    localparam logic [2:0] R_DE = 3'd1;
    localparam logic [2:0] R_HL = 3'd2;
    localparam logic [2:0] R_SP = 3'd3;
    localparam logic [2:0] R_AF = 3'd4;
    localparam logic [2:0] R_IX = 3'd5;
    localparam logic [2:0] R_IY = 3'd6;
    localparam logic [2:0] R_NONE = 3'd7;

    // Result kinds.
    localparam logic [2:0] K_MEM_WRITE  = 3'd0;
    localparam logic [2:0] K_REG_UPDATE = 3'd1;
    localparam logic [2:0] K_MEM_READ   = 3'd2;
    localparam logic [2:0] K_REG_READ   = 3'd3;
    localparam logic [2:0] K_ILLEGAL    = 3'd4;

    // Register file access request.
    typedef struct packed {
        logic                    re;
        logic [REG_IDX_BITS-1:0] raddr;
        logic                    we;
        logic [REG_IDX_BITS-1:0] waddr;
        logic [15:0]             wdata;
    } t_rf_req;

    // Byte memory access request.
    typedef struct packed {
        logic                 re;
        logic [ADDR_BITS-1:0] raddr;
        logic                 we;
        logic [ADDR_BITS-1:0] waddr;
        logic [7:0]           wdata;
    } t_mem_req;

    // A 16-bit address folded onto the memory size.
    function automatic logic [ADDR_BITS-1:0] mem_addr(input logic [15:0] a);
        return a[ADDR_BITS-1:0];
    endfunction

    // The folded address as reported on the result port.
    function automatic logic [15:0] report_addr(input logic [15:0] a);
        return 16'(a[ADDR_BITS-1:0]);
    endfunction

endpackage

>>> hw/rtl/z80_word_load_push_pop_unit.sv
// Top level of the Z80 16-bit load group unit.
// Depends on z80wl_pkg, z80wl_byte_mem, z80wl_regfile and z80wl_seq.
`timescale 1ns / 1ps

// Usage:
// A request is taken at a rising edge where i_start is high and o_busy is low.
// i_mode selects the operation, i_reg_sel the register pair, i_operand the
// immediate word or address, i_poke_byte the byte for a poke.
// Each result is shown for one cycle with o_valid high; o_last marks the final
// result of a request. The receiver cannot stall, so results are never held.
// The first result is registered in the step that takes the request for load
// immediate, poke and errors, and in the step after it for peek, load SP, load
// from memory and store. A push reads the register pair and then the stack
// pointer before its first result; a pop reads the stack pointer and then the
// byte memory. A new request is taken only once the sequencer is idle again.
// The sequencer uses the single read port of the register file and of the byte
// memory once per step, each with a registered read.
// Reset clears the sequencer and marks every register pair as zero at once;
// the byte memory is not cleared and a byte reads as undefined until written.

module z80_word_load_push_pop_unit
    import z80wl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [3:0]  i_mode,
    input  logic [2:0]  i_reg_sel,
    input  logic [15:0] i_operand,
    input  logic [7:0]  i_poke_byte,
    output logic        o_valid,
    output logic [2:0]  o_kind,
    output logic [15:0] o_address,
    output logic [7:0]  o_byte_value,
    output logic [15:0] o_reg_value,
    output logic        o_last
);

    t_rf_req     rf_req;
    t_mem_req    mem_req;
    logic [15:0] rf_rdata;
    logic [7:0]  mem_rdata;

    // Register pair storage.
    z80wl_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rf_req),
        .o_rdata (rf_rdata)
    );

    // Byte memory.
    z80wl_byte_mem u_byte_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // Request decode and step control.
    z80wl_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_mode       (i_mode),
        .i_reg_sel    (i_reg_sel),
        .i_operand    (i_operand),
        .i_poke_byte  (i_poke_byte),
        .i_rf_rdata   (rf_rdata),
        .i_mem_rdata  (mem_rdata),
        .o_rf_req     (rf_req),
        .o_mem_req    (mem_req),
        .o_valid      (o_valid),
        .o_kind       (o_kind),
        .o_address    (o_address),
        .o_byte_value (o_byte_value),
        .o_reg_value  (o_reg_value),
        .o_last       (o_last)
    );

endmodule

>>> hw/rtl/z80wl_byte_mem.sv
// Byte memory of the load group unit: one write and one read port, registered read.
// Depends on z80wl_pkg for the address width and the request type.
`timescale 1ns / 1ps

module z80wl_byte_mem
    import z80wl_pkg::*;
(
    input  logic       i_clk,
    input  t_mem_req   i_req,
    output logic [7:0] o_rdata
);

    logic [7:0] r_mem [0:MEM_DEPTH-1];
    logic [7:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Read port, registered.
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/z80wl_regfile.sv
// Register pair file of the load group unit: seven 16-bit entries, registered read.
// Depends on z80wl_pkg; entries read as zero until first written after reset.
`timescale 1ns / 1ps

module z80wl_regfile
    import z80wl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_rf_req     i_req,
    output logic [15:0] o_rdata
);

    logic [15:0]          r_mem [0:REG_COUNT-1];
    logic [REG_COUNT-1:0] r_valid;
    logic [15:0]          r_rdata;
    logic                 r_rvalid;

    // Write port; the payload array needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Valid bits stand in for the all-zero reset of the entries.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.we) begin
            r_valid[i_req.waddr] <= 1'b1;
        end
    end

    // Read port, registered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvalid <= 1'b0;
        end else if (i_req.re) begin
            r_rvalid <= r_valid[i_req.raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : 16'd0;

endmodule

>>> hw/rtl/z80wl_seq.sv
// Sequencer of the load group unit: decodes a request, drives the two memories
// step by step and registers each result. Depends on z80wl_pkg.
`timescale 1ns / 1ps

module z80wl_seq
    import z80wl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [3:0]  i_mode,
    input  logic [2:0]  i_reg_sel,
    input  logic [15:0] i_operand,
    input  logic [7:0]  i_poke_byte,
    input  logic [15:0] i_rf_rdata,
    input  logic [7:0]  i_mem_rdata,
    output t_rf_req     o_rf_req,
    output t_mem_req    o_mem_req,
    output logic        o_valid,
    output logic [2:0]  o_kind,
    output logic [15:0] o_address,
    output logic [7:0]  o_byte_value,
    output logic [15:0] o_reg_value,
    output logic        o_last
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MR   = 4'd1;
    localparam logic [3:0] S_RR   = 4'd2;
    localparam logic [3:0] S_LM1  = 4'd3;
    localparam logic [3:0] S_LM2  = 4'd4;
    localparam logic [3:0] S_FIN  = 4'd5;
    localparam logic [3:0] S_SM1  = 4'd6;
    localparam logic [3:0] S_SM2  = 4'd7;
    localparam logic [3:0] S_LS   = 4'd8;
    localparam logic [3:0] S_PU1  = 4'd9;
    localparam logic [3:0] S_PU2  = 4'd10;
    localparam logic [3:0] S_PU3  = 4'd11;
    localparam logic [3:0] S_PO1  = 4'd12;
    localparam logic [3:0] S_PO2  = 4'd13;
    localparam logic [3:0] S_PO3  = 4'd14;

    logic [3:0]  r_state, n_state;
    logic [2:0]  r_sel, n_sel;
    logic [15:0] r_addr, n_addr;
    logic [15:0] r_val, n_val;

    logic        r_valid, n_valid;
    logic [2:0]  r_kind, n_kind;
    logic [15:0] r_address, n_address;
    logic [7:0]  r_byte, n_byte;
    logic [15:0] r_regv, n_regv;
    logic        r_last, n_last;

    logic        accept;
    logic        bad;
    logic [15:0] sp_dec;

    assign accept = i_start && (r_state == S_IDLE);
    assign sp_dec = i_rf_rdata - 16'd1;

    // Legality of the register choice for each mode.
    always_comb begin
        case (i_mode)
            M_LD_IMM, M_LD_MEM, M_ST_MEM: bad = (i_reg_sel == R_NONE) || (i_reg_sel == R_AF);
            M_LD_SP:    bad = !((i_reg_sel == R_HL) || (i_reg_sel == R_IX) ||
                                (i_reg_sel == R_IY));
            M_PUSH, M_POP: bad = (i_reg_sel == R_NONE) || (i_reg_sel == R_SP);
            M_POKE, M_PEEK_MEM: bad = 1'b0;
            M_PEEK_REG: bad = (i_reg_sel == R_NONE);
            default:    bad = 1'b1;
        endcase
    end

    // Step logic: memory requests, next state and the next result.
    always_comb begin
        n_state   = r_state;
        n_sel     = r_sel;
        n_addr    = r_addr;
        n_val     = r_val;
        n_valid   = 1'b0;
        n_kind    = K_MEM_WRITE;
        n_address = 16'd0;
        n_byte    = 8'd0;
        n_regv    = 16'd0;
        n_last    = 1'b0;
        o_rf_req  = '0;
        o_mem_req = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_sel  = i_reg_sel;
                    n_addr = i_operand;
                    if (bad) begin
                        n_valid = 1'b1;
                        n_kind  = K_ILLEGAL;
                        n_last  = 1'b1;
                    end else begin
                        case (i_mode)
                            M_LD_IMM: begin
                                o_rf_req.we    = 1'b1;
                                o_rf_req.waddr = i_reg_sel;
                                o_rf_req.wdata = i_operand;
                                n_valid = 1'b1;
                                n_kind  = K_REG_UPDATE;
                                n_regv  = i_operand;
                                n_last  = 1'b1;
                            end
                            M_LD_MEM: begin
                                o_mem_req.re    = 1'b1;
                                o_mem_req.raddr = mem_addr(i_operand);
                                n_state = S_LM1;
                            end
                            M_ST_MEM: begin
                                o_rf_req.re    = 1'b1;
                                o_rf_req.raddr = i_reg_sel;
                                n_state = S_SM1;
                            end
                            M_LD_SP: begin
                                o_rf_req.re    = 1'b1;
                                o_rf_req.raddr = i_reg_sel;
                                n_state = S_LS;
                            end
                            M_PUSH: begin
                                o_rf_req.re    = 1'b1;
                                o_rf_req.raddr = i_reg_sel;
                                n_state = S_PU1;
                            end
                            M_POP: begin
                                o_rf_req.re    = 1'b1;
                                o_rf_req.raddr = R_SP;
                                n_state = S_PO1;
                            end
                            M_POKE: begin
                                o_mem_req.we    = 1'b1;
                                o_mem_req.waddr = mem_addr(i_operand);
                                o_mem_req.wdata = i_poke_byte;
                                n_valid   = 1'b1;
                                n_kind    = K_MEM_WRITE;
                                n_address = report_addr(i_operand);
                                n_byte    = i_poke_byte;
                                n_last    = 1'b1;
                            end
                            M_PEEK_MEM: begin
                                o_mem_req.re    = 1'b1;
                                o_mem_req.raddr = mem_addr(i_operand);
                                n_state = S_MR;
                            end
                            default: begin
                                o_rf_req.re    = 1'b1;
                                o_rf_req.raddr = i_reg_sel;
                                n_state = S_RR;
                            end
                        endcase
                    end
                end
            end
            S_MR: begin
                n_valid   = 1'b1;
                n_kind    = K_MEM_READ;
                n_address = report_addr(r_addr);
                n_byte    = i_mem_rdata;
                n_last    = 1'b1;
                n_state   = S_IDLE;
            end
            S_RR: begin
                n_valid = 1'b1;
                n_kind  = K_REG_READ;
                n_regv  = i_rf_rdata;
                n_last  = 1'b1;
                n_state = S_IDLE;
            end
            S_LM1, S_PO2: begin
                // Low byte arrived; fetch the high byte at the next address.
                n_valid         = 1'b1;
                n_kind          = K_MEM_READ;
                n_address       = report_addr(r_addr);
                n_byte          = i_mem_rdata;
                n_val[7:0]      = i_mem_rdata;
                n_addr          = r_addr + 16'd1;
                o_mem_req.re    = 1'b1;
                o_mem_req.raddr = mem_addr(n_addr);
                n_state         = (r_state == S_LM1) ? S_LM2 : S_PO3;
            end
            S_LM2: begin
                n_valid     = 1'b1;
                n_kind      = K_MEM_READ;
                n_address   = report_addr(r_addr);
                n_byte      = i_mem_rdata;
                n_val[15:8] = i_mem_rdata;
                n_state     = S_FIN;
            end
            S_FIN: begin
                o_rf_req.we    = 1'b1;
                o_rf_req.waddr = r_sel;
                o_rf_req.wdata = r_val;
                n_valid = 1'b1;
                n_kind  = K_REG_UPDATE;
                n_regv  = r_val;
                n_last  = 1'b1;
                n_state = S_IDLE;
            end
            S_SM1: begin
                n_val           = i_rf_rdata;
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = mem_addr(r_addr);
                o_mem_req.wdata = i_rf_rdata[7:0];
                n_valid         = 1'b1;
                n_kind          = K_MEM_WRITE;
                n_address       = report_addr(r_addr);
                n_byte          = i_rf_rdata[7:0];
                n_addr          = r_addr + 16'd1;
                n_state         = S_SM2;
            end
            S_SM2, S_PU3: begin
                // Final byte of a store: high byte for a store, low byte for a push.
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = mem_addr(r_addr);
                o_mem_req.wdata = (r_state == S_SM2) ? r_val[15:8] : r_val[7:0];
                n_valid         = 1'b1;
                n_kind          = K_MEM_WRITE;
                n_address       = report_addr(r_addr);
                n_byte          = o_mem_req.wdata;
                n_last          = 1'b1;
                n_state         = S_IDLE;
                if (r_state == S_PU3) begin
                    o_rf_req.we    = 1'b1;
                    o_rf_req.waddr = R_SP;
                    o_rf_req.wdata = r_addr;
                end
            end
            S_LS: begin
                o_rf_req.we    = 1'b1;
                o_rf_req.waddr = R_SP;
                o_rf_req.wdata = i_rf_rdata;
                n_valid = 1'b1;
                n_kind  = K_REG_UPDATE;
                n_regv  = i_rf_rdata;
                n_last  = 1'b1;
                n_state = S_IDLE;
            end
            S_PU1: begin
                n_val          = i_rf_rdata;
                o_rf_req.re    = 1'b1;
                o_rf_req.raddr = R_SP;
                n_state        = S_PU2;
            end
            S_PU2: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = mem_addr(sp_dec);
                o_mem_req.wdata = r_val[15:8];
                n_valid         = 1'b1;
                n_kind          = K_MEM_WRITE;
                n_address       = report_addr(sp_dec);
                n_byte          = r_val[15:8];
                n_addr          = sp_dec - 16'd1;
                n_state         = S_PU3;
            end
            S_PO1: begin
                n_addr          = i_rf_rdata;
                o_mem_req.re    = 1'b1;
                o_mem_req.raddr = mem_addr(i_rf_rdata);
                n_state         = S_PO2;
            end
            S_PO3: begin
                n_valid        = 1'b1;
                n_kind         = K_MEM_READ;
                n_address      = report_addr(r_addr);
                n_byte         = i_mem_rdata;
                n_val[15:8]    = i_mem_rdata;
                o_rf_req.we    = 1'b1;
                o_rf_req.waddr = R_SP;
                o_rf_req.wdata = r_addr + 16'd1;
                n_state        = S_FIN;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge i_clk) begin
        r_sel     <= n_sel;
        r_addr    <= n_addr;
        r_val     <= n_val;
        r_kind    <= n_kind;
        r_address <= n_address;
        r_byte    <= n_byte;
        r_regv    <= n_regv;
        r_last    <= n_last;
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_address    = r_address;
    assign o_byte_value = r_byte;
    assign o_reg_value  = r_regv;
    assign o_last       = r_last;

    // An illegal request answers with one final error result in the next cycle.
    a_illegal_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && bad) |=> (r_valid && r_last && (r_kind == K_ILLEGAL) &&
                             (r_state == S_IDLE)))
        else $error("illegal request did not give a single error result");

    // The final result of an item appears exactly when the sequencer is idle again.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_last == (r_state == S_IDLE)))
        else $error("final result flag out of step with the sequencer");

    // No step reads and writes the same register pair in one cycle.
    a_rf_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_rf_req.re && o_rf_req.we && (o_rf_req.raddr == o_rf_req.waddr)))
        else $error("register file read and write collide");

    // A push ends by writing back the twice-decremented stack pointer.
    a_push_sp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PU2) |=> (o_rf_req.we && (o_rf_req.waddr == R_SP) &&
                                (o_rf_req.wdata == $past(sp_dec) - 16'd1)))
        else $error("push did not update the stack pointer");

endmodule
